>>> rtl/qcp_pkg.sv
// Shared types, constants and tables of the quaternion camera pose block.
`timescale 1ns / 1ps
package qcp_pkg;

  localparam int CORDIC_ITERATIONS = 24;

  localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
  localparam logic signed [31:0] DEG_HALF_K  = 32'sd37480660;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [2:0] OP_ROTATE    = 3'd0;
  localparam logic [2:0] OP_TRANSLATE = 3'd1;
  localparam logic [2:0] OP_SET_POS   = 3'd2;
  localparam logic [2:0] OP_LATCH     = 3'd3;
  localparam logic [2:0] OP_RESET     = 3'd4;

  localparam logic [4:0] N_THETA = 5'd1;
  localparam logic [4:0] N_RQ    = 5'd3;
  localparam logic [4:0] N_HAM   = 5'd16;
  localparam logic [4:0] N_SQS   = 5'd4;
  localparam logic [4:0] N_MAT   = 5'd9;

  typedef enum logic [3:0] {
    S_IDLE, S_THETA, S_CORDIC_GO, S_CORDIC_WAIT, S_RQ, S_HAM, S_MAG, S_SQS,
    S_SQRT_GO, S_SQRT_WAIT, S_DIV_GO, S_DIV_WAIT, S_MAT, S_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } rd_req_t;

  typedef struct packed {
    logic [1:0] ai;
    logic [1:0] bi;
    logic       neg;
  } ham_term_t;

  typedef struct packed {
    logic [1:0] ai;
    logic [1:0] bi;
  } mat_pair_t;

  // arctan(2^-i) in Q2.30.
  function automatic logic [31:0] atan_val(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h3243F6A8;  5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;  5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;  5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;  5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;  5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;  5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;  5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;  5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;  5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;  5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;  5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;  5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;  5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;  5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;  5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;  default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // Hamilton product terms, four per output component (index = comp*4 + term).
  function automatic ham_term_t ham_term(input logic [3:0] idx);
    ham_term_t t;
    case (idx)
      4'd0:  t = '{2'd3, 2'd0, 1'b0};  4'd1:  t = '{2'd0, 2'd3, 1'b0};
      4'd2:  t = '{2'd1, 2'd2, 1'b0};  4'd3:  t = '{2'd2, 2'd1, 1'b1};
      4'd4:  t = '{2'd3, 2'd1, 1'b0};  4'd5:  t = '{2'd0, 2'd2, 1'b1};
      4'd6:  t = '{2'd1, 2'd3, 1'b0};  4'd7:  t = '{2'd2, 2'd0, 1'b0};
      4'd8:  t = '{2'd3, 2'd2, 1'b0};  4'd9:  t = '{2'd0, 2'd1, 1'b0};
      4'd10: t = '{2'd1, 2'd0, 1'b1};  4'd11: t = '{2'd2, 2'd3, 1'b0};
      4'd12: t = '{2'd3, 2'd3, 1'b0};  4'd13: t = '{2'd0, 2'd0, 1'b1};
      4'd14: t = '{2'd1, 2'd1, 1'b1};  default: t = '{2'd2, 2'd2, 1'b1};
    endcase
    return t;
  endfunction

  // Matrix products: xx yy zz xy xz yz xw yw zw.
  function automatic mat_pair_t mat_pair(input logic [3:0] idx);
    mat_pair_t p;
    case (idx)
      4'd0: p = '{2'd0, 2'd0};  4'd1: p = '{2'd1, 2'd1};
      4'd2: p = '{2'd2, 2'd2};  4'd3: p = '{2'd0, 2'd1};
      4'd4: p = '{2'd0, 2'd2};  4'd5: p = '{2'd1, 2'd2};
      4'd6: p = '{2'd0, 2'd3};  4'd7: p = '{2'd1, 2'd3};
      default: p = '{2'd2, 2'd3};
    endcase
    return p;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -48'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

>>> rtl/qcp_mul.sv
// Shared signed 32 by 32 multiplier with a registered product.
`timescale 1ns / 1ps
module qcp_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

>>> rtl/qcp_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
`timescale 1ns / 1ps
module qcp_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [33:0] theta,
  output logic               done_r,
  output logic signed [33:0] cos_r,
  output logic signed [33:0] sin_r
);

  logic signed [33:0] z_r;
  logic [4:0]         i_r;
  logic               busy_r;
  logic signed [33:0] atan_s;
  logic               last;

  assign atan_s = {2'b00, qcp_pkg::atan_val(i_r)};
  assign last   = (i_r == 5'(qcp_pkg::CORDIC_ITERATIONS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        i_r    <= '0;
        cos_r  <= qcp_pkg::CORDIC_GAIN;
        sin_r  <= '0;
        z_r    <= theta;
      end else if (busy_r) begin
        if (!z_r[33]) begin
          cos_r <= cos_r - (sin_r >>> i_r);
          sin_r <= sin_r + (cos_r >>> i_r);
          z_r   <= z_r - atan_s;
        end else begin
          cos_r <= cos_r + (sin_r >>> i_r);
          sin_r <= sin_r - (cos_r >>> i_r);
          z_r   <= z_r + atan_s;
        end
        i_r <= i_r + 5'd1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/qcp_root_div.sv
// Bit-serial unit: 64-bit integer square root or 62 by 32 bit division.
`timescale 1ns / 1ps
module qcp_root_div (
  input  logic             clk,
  input  logic             rst_n,
  input  qcp_pkg::rd_req_t req,
  input  logic [63:0]      radicand,
  input  logic [61:0]      num,
  input  logic [31:0]      den,
  output logic             done_r,
  output logic [31:0]      result
);

  logic        busy_r, div_r;
  logic [4:0]  cnt_r;
  logic [63:0] n_r, res_r, bit_r;
  logic [64:0] trial;
  logic        sq_ge;
  logic [32:0] rem_r;
  logic [31:0] nlo_r, qt_r, den_r;
  logic [33:0] dtrial;
  logic        dv_ge;

  assign trial  = {1'b0, res_r} + {1'b0, bit_r};
  assign sq_ge  = ({1'b0, n_r} >= trial);
  assign dtrial = {rem_r, nlo_r[31]};
  assign dv_ge  = (dtrial >= {2'b00, den_r});
  assign result = div_r ? qt_r : res_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        div_r  <= req.is_div;
        cnt_r  <= '0;
        n_r    <= radicand;
        res_r  <= '0;
        bit_r  <= 64'h4000_0000_0000_0000;
        // The quotient is known to fit 32 bits, so the top part starts as the remainder.
        rem_r  <= {3'b000, num[61:32]};
        nlo_r  <= num[31:0];
        qt_r   <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        if (div_r) begin
          rem_r <= dv_ge ? 33'(dtrial - {2'b00, den_r}) : dtrial[32:0];
          nlo_r <= {nlo_r[30:0], 1'b0};
          qt_r  <= {qt_r[30:0], dv_ge};
        end else begin
          if (sq_ge) begin
            n_r   <= 64'({1'b0, n_r} - trial);
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/quaternion_camera_pose_top.sv
// Top level of the quaternion camera pose block: sequencer, state and view matrix output.
`timescale 1ns / 1ps
// Channel | Dir | Payload
// in_     | in  | tuser: opcode; tdata: angle_deg, local_space, vec_x, vec_y, vec_z
// out_    | out | tuser: row_index; tdata: col_a..col_d; tlast: last_row
//
// One command is taken at a time; in_tready is high only while the sequencer is idle.
// A rotation uses one shared multiplier for 33 products, one per cycle within each
// multiply phase; the CORDIC runs 24 micro-rotations, and a bit-serial unit runs 32
// steps for the square root and 32 for each of the four divisions. Other commands go
// straight to the matrix products and the four output beats. The rows sit in an output
// register, so a stalled out_tready only holds the sequencer in its output state. Reset is
// synchronous and active low and restores the identity orientation with zero positions.
module quaternion_camera_pose_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [15:0] angle_deg, [16] local_space, [48:17] vec_x, [80:49] vec_y, [112:81] vec_z
  input  logic [119:0] in_tdata,
  // [2:0] opcode
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [47:0] col_a, [95:48] col_b, [143:96] col_c, [191:144] col_d
  output logic [191:0] out_tdata,
  // [1:0] row_index
  output logic [1:0]   out_tuser,
  output logic         out_tlast
);

  qcp_pkg::state_t state_r, state_nxt;
  logic [4:0] cnt_r;
  logic [1:0] didx_r;

  // Architectural state: orientation (Q2.30), position and home position (Q16.16).
  logic signed [31:0] q_r [4];
  logic signed [31:0] pos_r [3];
  logic signed [31:0] home_r [3];

  // Captured command.
  logic signed [15:0] angle_r;
  logic               local_r;
  logic signed [31:0] vec_r [3];
  logic               ident_r;

  // Working registers of a rotation.
  logic signed [33:0] theta_r;
  logic signed [31:0] r_r [4];
  logic signed [35:0] qn_r [4];
  logic [30:0]        mg_r [4];
  logic               neg_r [4];
  logic [63:0]        sum_r;
  logic [31:0]        m_r;
  logic signed [33:0] prod_r [9];

  logic               out_tvalid_r;
  logic [191:0]       out_tdata_r;
  logic [1:0]         out_tuser_r;
  logic               out_tlast_r;

  logic               in_fire, out_load, cordic_start;
  qcp_pkg::rd_req_t   rd_req;
  logic               cordic_done, rd_done;
  logic signed [33:0] cos_v, sin_v;
  logic [31:0]        rd_result;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic [4:0]         cidx;
  qcp_pkg::ham_term_t ht_d;
  logic signed [63:0] p_q30, p_q16, p_q10;
  logic signed [33:0] mq;
  logic [61:0]        div_num;
  logic [35:0]        mag [4];
  logic [35:0]        maxm;
  logic [2:0]         sh;
  logic [47:0]        row_a, row_b, row_c, row_d;
  logic [2:0]         op_in;
  logic signed [31:0] in_vec [3];

  assign op_in     = in_tuser;
  assign in_vec[0] = in_tdata[48:17];
  assign in_vec[1] = in_tdata[80:49];
  assign in_vec[2] = in_tdata[112:81];
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = (state_r == qcp_pkg::S_OUT) && (!out_tvalid_r || out_tready);
  assign cidx      = cnt_r - 5'd1;
  // Hamilton term whose product returns in this cycle.
  assign ht_d      = qcp_pkg::ham_term(cidx[3:0]);

  // Rounded product scalings: add half, then arithmetic shift.
  assign p_q30 = mul_p + 64'sd536870912;
  assign p_q16 = mul_p + 64'sd32768;
  assign p_q10 = mul_p + 64'sd512;
  assign mq    = p_q30[63:30];

  assign div_num = {mg_r[didx_r], 30'b0} + {31'b0, m_r[31:1]};

  qcp_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  qcp_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cordic_start),
    .theta  (theta_r),
    .done_r (cordic_done),
    .cos_r  (cos_v),
    .sin_r  (sin_v)
  );

  qcp_root_div u_root_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (rd_req),
    .radicand (sum_r),
    .num      (div_num),
    .den      (m_r),
    .done_r   (rd_done),
    .result   (rd_result)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      qcp_pkg::S_IDLE: begin
        if (in_fire) begin
          case (op_in)
            qcp_pkg::OP_ROTATE: state_nxt = qcp_pkg::S_THETA;
            qcp_pkg::OP_TRANSLATE, qcp_pkg::OP_SET_POS, qcp_pkg::OP_LATCH,
            qcp_pkg::OP_RESET: state_nxt = qcp_pkg::S_MAT;
            default: state_nxt = qcp_pkg::S_IDLE;
          endcase
        end
      end
      qcp_pkg::S_THETA:
        if (cnt_r == qcp_pkg::N_THETA) state_nxt = qcp_pkg::S_CORDIC_GO;
      qcp_pkg::S_CORDIC_GO: state_nxt = qcp_pkg::S_CORDIC_WAIT;
      qcp_pkg::S_CORDIC_WAIT:
        if (cordic_done) state_nxt = qcp_pkg::S_RQ;
      qcp_pkg::S_RQ:
        if (cnt_r == qcp_pkg::N_RQ) state_nxt = qcp_pkg::S_HAM;
      qcp_pkg::S_HAM:
        if (cnt_r == qcp_pkg::N_HAM) state_nxt = qcp_pkg::S_MAG;
      qcp_pkg::S_MAG: state_nxt = qcp_pkg::S_SQS;
      qcp_pkg::S_SQS:
        if (cnt_r == qcp_pkg::N_SQS) state_nxt = qcp_pkg::S_SQRT_GO;
      qcp_pkg::S_SQRT_GO: state_nxt = qcp_pkg::S_SQRT_WAIT;
      qcp_pkg::S_SQRT_WAIT: begin
        if (rd_done) begin
          // A zero norm leaves the orientation as it was.
          state_nxt = (rd_result == 32'd0) ? qcp_pkg::S_MAT : qcp_pkg::S_DIV_GO;
        end
      end
      qcp_pkg::S_DIV_GO: state_nxt = qcp_pkg::S_DIV_WAIT;
      qcp_pkg::S_DIV_WAIT: begin
        if (rd_done) begin
          state_nxt = (didx_r == 2'd3) ? qcp_pkg::S_MAT : qcp_pkg::S_DIV_GO;
        end
      end
      qcp_pkg::S_MAT:
        if (cnt_r == qcp_pkg::N_MAT) state_nxt = qcp_pkg::S_OUT;
      qcp_pkg::S_OUT:
        if (out_load && cnt_r == 5'd3) state_nxt = qcp_pkg::S_IDLE;
      default: state_nxt = qcp_pkg::S_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_tready     = 1'b0;
    cordic_start  = 1'b0;
    rd_req.start  = 1'b0;
    rd_req.is_div = 1'b0;
    unique case (state_r)
      qcp_pkg::S_IDLE:      in_tready = 1'b1;
      qcp_pkg::S_CORDIC_GO: cordic_start = 1'b1;
      qcp_pkg::S_SQRT_GO:   rd_req.start = 1'b1;
      qcp_pkg::S_DIV_GO: begin
        rd_req.start  = 1'b1;
        rd_req.is_div = 1'b1;
      end
      default: ;
    endcase
  end

  // Multiplier operand selection for the product issued in this cycle.
  always_comb begin
    qcp_pkg::ham_term_t ht;
    qcp_pkg::mat_pair_t mp;
    ht    = qcp_pkg::ham_term(cnt_r[3:0]);
    mp    = qcp_pkg::mat_pair(cnt_r[3:0]);
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      qcp_pkg::S_THETA: begin
        mul_a = {{16{angle_r[15]}}, angle_r};
        mul_b = qcp_pkg::DEG_HALF_K;
      end
      qcp_pkg::S_RQ: begin
        mul_a = vec_r[cnt_r[1:0] == 2'd3 ? 2'd0 : cnt_r[1:0]];
        mul_b = sin_v[31:0];
      end
      qcp_pkg::S_HAM: begin
        mul_a = local_r ? r_r[ht.ai] : q_r[ht.ai];
        mul_b = local_r ? q_r[ht.bi] : r_r[ht.bi];
      end
      qcp_pkg::S_SQS: begin
        mul_a = {1'b0, mg_r[cnt_r[1:0]]};
        mul_b = {1'b0, mg_r[cnt_r[1:0]]};
      end
      qcp_pkg::S_MAT: begin
        mul_a = q_r[mp.ai];
        mul_b = q_r[mp.bi];
      end
      default: ;
    endcase
  end

  // Magnitudes and the pre-scale that brings them below 2^31.
  always_comb begin
    maxm = '0;
    for (int k = 0; k < 4; k++) begin
      mag[k] = qn_r[k][35] ? 36'(-qn_r[k]) : 36'(qn_r[k]);
      if (mag[k] > maxm) maxm = mag[k];
    end
    if (maxm[35])      sh = 3'd5;
    else if (maxm[34]) sh = 3'd4;
    else if (maxm[33]) sh = 3'd3;
    else if (maxm[32]) sh = 3'd2;
    else if (maxm[31]) sh = 3'd1;
    else               sh = 3'd0;
  end

  // View matrix row for the current output beat.
  always_comb begin
    logic signed [47:0] xx, yy, zz, xy, xz, yz, xw, yw, zw, one;
    logic signed [47:0] pd;
    xx  = 48'(prod_r[0]);  yy = 48'(prod_r[1]);  zz = 48'(prod_r[2]);
    xy  = 48'(prod_r[3]);  xz = 48'(prod_r[4]);  yz = 48'(prod_r[5]);
    xw  = 48'(prod_r[6]);  yw = 48'(prod_r[7]);  zw = 48'(prod_r[8]);
    one = 48'(qcp_pkg::ONE_Q30);
    pd  = ident_r ? 48'sd0 : -(48'(pos_r[cnt_r[1:0] == 2'd3 ? 2'd0 : cnt_r[1:0]]) <<< 14);
    case (cnt_r[1:0])
      2'd0: begin
        row_a = one - ((yy + zz) <<< 1);
        row_b = (xy - zw) <<< 1;
        row_c = (xz + yw) <<< 1;
        row_d = pd;
      end
      2'd1: begin
        row_a = (xy + zw) <<< 1;
        row_b = one - ((xx + zz) <<< 1);
        row_c = (yz - xw) <<< 1;
        row_d = pd;
      end
      2'd2: begin
        row_a = (xz - yw) <<< 1;
        row_b = (yz + xw) <<< 1;
        row_c = one - ((xx + yy) <<< 1);
        row_d = pd;
      end
      default: begin
        row_a = '0;
        row_b = '0;
        row_c = '0;
        row_d = one;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= qcp_pkg::S_IDLE;
      cnt_r        <= '0;
      didx_r       <= '0;
      out_tvalid_r <= 1'b0;
      q_r[0] <= '0;  q_r[1] <= '0;  q_r[2] <= '0;  q_r[3] <= qcp_pkg::ONE_Q30;
      for (int k = 0; k < 3; k++) begin
        pos_r[k]  <= '0;
        home_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_nxt != state_r) cnt_r <= '0;
      else if (state_r != qcp_pkg::S_OUT || out_load) cnt_r <= cnt_r + 5'd1;

      if (out_load) begin
        out_tvalid_r <= 1'b1;
        out_tdata_r  <= {row_d, row_c, row_b, row_a};
        out_tuser_r  <= cnt_r[1:0];
        out_tlast_r  <= (cnt_r[1:0] == 2'd3);
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      // Command capture; position commands take effect at once.
      if (in_fire) begin
        angle_r <= in_tdata[15:0];
        local_r <= in_tdata[16];
        ident_r <= (op_in == qcp_pkg::OP_RESET);
        for (int k = 0; k < 3; k++) vec_r[k] <= in_vec[k];
        case (op_in)
          qcp_pkg::OP_TRANSLATE: begin
            for (int k = 0; k < 3; k++)
              pos_r[k] <= qcp_pkg::sat32(48'(pos_r[k]) + 48'(in_vec[k]));
          end
          qcp_pkg::OP_SET_POS: begin
            for (int k = 0; k < 3; k++) pos_r[k] <= in_vec[k];
          end
          qcp_pkg::OP_LATCH: begin
            for (int k = 0; k < 3; k++) begin
              pos_r[k]  <= qcp_pkg::sat32(48'(pos_r[k]) + 48'(in_vec[k]));
              home_r[k] <= qcp_pkg::sat32(48'(pos_r[k]) + 48'(in_vec[k]));
            end
          end
          qcp_pkg::OP_RESET: begin
            for (int k = 0; k < 3; k++) pos_r[k] <= home_r[k];
            q_r[0] <= '0;  q_r[1] <= '0;  q_r[2] <= '0;
            q_r[3] <= qcp_pkg::ONE_Q30;
          end
          default: ;
        endcase
      end

      // Each multiply phase consumes the product issued in the cycle before.
      case (state_r)
        qcp_pkg::S_THETA:
          if (cnt_r != 5'd0) theta_r <= p_q10[43:10];
        qcp_pkg::S_RQ: begin
          if (cnt_r != 5'd0) r_r[cidx[1:0]] <= qcp_pkg::sat32(p_q16[63:16]);
          r_r[3] <= qcp_pkg::sat32(48'(cos_v));
        end
        qcp_pkg::S_HAM: begin
          if (cnt_r == 5'd0) begin
            for (int k = 0; k < 4; k++) qn_r[k] <= '0;
          end else if (ht_d.neg) begin
            qn_r[cidx[3:2]] <= qn_r[cidx[3:2]] - 36'(mq);
          end else begin
            qn_r[cidx[3:2]] <= qn_r[cidx[3:2]] + 36'(mq);
          end
        end
        qcp_pkg::S_MAG: begin
          for (int k = 0; k < 4; k++) begin
            mg_r[k]  <= 31'(mag[k] >> sh);
            neg_r[k] <= qn_r[k][35];
          end
        end
        qcp_pkg::S_SQS: begin
          if (cnt_r == 5'd0) sum_r <= '0;
          else sum_r <= sum_r + mul_p;
        end
        qcp_pkg::S_SQRT_WAIT: begin
          didx_r <= '0;
          if (rd_done) m_r <= rd_result;
        end
        qcp_pkg::S_DIV_WAIT: begin
          if (rd_done) begin
            q_r[didx_r] <= neg_r[didx_r] ? -rd_result : rd_result;
            didx_r      <= didx_r + 2'd1;
          end
        end
        qcp_pkg::S_MAT:
          if (cnt_r != 5'd0) prod_r[cidx[3:0]] <= mq;
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  // A valid command with a defined opcode always takes the block busy in the next cycle.
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == qcp_pkg::OP_ROTATE ||
    in_tuser == qcp_pkg::OP_TRANSLATE || in_tuser == qcp_pkg::OP_SET_POS ||
    in_tuser == qcp_pkg::OP_LATCH || in_tuser == qcp_pkg::OP_RESET) |=> !in_tready)
    else $error("block still ready after a command");

  // The CORDIC only finishes while the sequencer waits on it.
  a_cordic_done: assert property (@(posedge clk) disable iff (!rst_n)
    cordic_done |-> state_r == qcp_pkg::S_CORDIC_WAIT)
    else $error("CORDIC finished outside its wait state");

  // The shared root/divide unit only finishes while the sequencer waits on it.
  a_rd_done: assert property (@(posedge clk) disable iff (!rst_n)
    rd_done |-> (state_r == qcp_pkg::S_SQRT_WAIT || state_r == qcp_pkg::S_DIV_WAIT))
    else $error("root/divide unit finished outside a wait state");

  // The last beat of a matrix is row three.
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == 2'd3)))
    else $error("tlast does not match the row index");

endmodule
